>>> sv/ordered_timer_queue_defines.svh
// assertion macros for the timer queue
`ifndef ORDERED_TIMER_QUEUE_DEFINES_SVH
`define ORDERED_TIMER_QUEUE_DEFINES_SVH
`ifndef ASSERT_OFF
`define OTQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define OTQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define OTQ_ASSERT(lbl, prop, msg)
`define OTQ_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> sv/otq_pkg.sv
package otq_pkg;
  localparam int CAPACITY_DEF = 16;
  localparam int ID_W = 16;
  localparam int TM_W = 48;
  localparam int IV_W = 32;
  localparam logic [IV_W-1:0] MIN_DELAY_RST = 32'd100;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ADD, ST_POP, ST_FIRE, ST_REINS, ST_STAT
  } state_t;

  typedef struct packed {
    logic latch_in;
    logic do_add;
    logic do_pop;
    logic do_reins;
    logic load_fire;
    logic load_stat;
  } cmd_t;

  typedef struct packed {
    logic is_tick;
    logic expired;
    logic reins_needed;
    logic out_free;
  } stat_t;
endpackage

>>> sv/otq_if.sv
interface otq_in_if;
  logic                      valid;
  logic                      ready;
  logic                      action;
  logic [otq_pkg::ID_W-1:0]  timer_id;
  logic [otq_pkg::TM_W-1:0]  deadline;
  logic [otq_pkg::IV_W-1:0]  repeat_interval;
  logic [otq_pkg::TM_W-1:0]  now;
  modport source (output valid, action, timer_id, deadline, repeat_interval, now,
                  input ready);
  modport sink (input valid, action, timer_id, deadline, repeat_interval, now,
                output ready);
endinterface

interface otq_out_if;
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic [otq_pkg::ID_W-1:0]  fired_id;
  logic                      head_changed;
  logic                      overflow;
  logic                      queue_nonempty;
  logic [otq_pkg::TM_W-1:0]  next_deadline;
  logic [otq_pkg::TM_W-1:0]  arm_delay;
  logic                      last;
  modport source (output valid, kind, fired_id, head_changed, overflow,
                  queue_nonempty, next_deadline, arm_delay, last, input ready);
  modport sink (input valid, kind, fired_id, head_changed, overflow,
                queue_nonempty, next_deadline, arm_delay, last, output ready);
endinterface

>>> sv/otq_ctrl.sv
module otq_ctrl import otq_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  stat_t stat,
  output cmd_t  cmd
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_ADD;
      end
      ST_ADD: begin
        if (stat.is_tick) state_next = ST_POP;
        else state_next = ST_STAT;
      end
      ST_POP: begin
        if (stat.expired) state_next = ST_FIRE;
        else state_next = ST_STAT;
      end
      ST_FIRE: begin
        if (stat.out_free) state_next = stat.reins_needed ? ST_REINS : ST_POP;
      end
      ST_REINS: begin
        state_next = ST_POP;
      end
      ST_STAT: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      ST_IDLE:  cmd.latch_in = in_valid;
      ST_ADD:   cmd.do_add = !stat.is_tick;
      ST_POP:   cmd.do_pop = stat.expired;
      ST_FIRE:  cmd.load_fire = stat.out_free;
      ST_REINS: cmd.do_reins = 1'b1;
      ST_STAT:  cmd.load_stat = stat.out_free;
      default:  cmd = '0;
    endcase
  end
endmodule

>>> sv/otq_dp.sv
`include "ordered_timer_queue_defines.svh"
module otq_dp import otq_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_wr_en,
  input  logic [IV_W-1:0] cfg_wr_data,
  otq_in_if.sink          in_ch,
  otq_out_if.source       out_ch,
  input  cmd_t            cmd,
  output stat_t           stat
);
  localparam int CW = $clog2(CAPACITY + 1);

  logic [TM_W-1:0] d_q [CAPACITY];
  logic [IV_W-1:0] iv_q [CAPACITY];
  logic [ID_W-1:0] id_q [CAPACITY];
  logic [CW-1:0]   count;
  logic [IV_W-1:0] min_delay;

  logic            r_action;
  logic [ID_W-1:0] r_id;
  logic [TM_W-1:0] r_dl;
  logic [IV_W-1:0] r_iv;
  logic [TM_W-1:0] r_now;
  logic [ID_W-1:0] h_id;
  logic [IV_W-1:0] h_iv;
  logic            ec, ov;

  logic            o_valid, o_kind, o_ec, o_ov, o_ne, o_last;
  logic [ID_W-1:0] o_id;
  logic [TM_W-1:0] o_nd, o_ad;

  logic            full, nonempty, do_ins;
  logic [TM_W:0]   sum;
  logic [TM_W-1:0] key, diff, ad;
  logic [IV_W-1:0] key_iv;
  logic [ID_W-1:0] key_id;
  logic [CAPACITY-1:0] le;

  assign full     = count == CW'(CAPACITY);
  assign nonempty = count != '0;
  assign do_ins   = (cmd.do_add && !full) || cmd.do_reins;
  assign sum      = {1'b0, r_now} + {{(TM_W + 1 - IV_W){1'b0}}, h_iv};

  always_comb begin
    if (cmd.do_reins) begin
      key    = sum[TM_W] ? {TM_W{1'b1}} : sum[TM_W-1:0];
      key_iv = h_iv;
      key_id = h_id;
    end else begin
      key    = r_dl;
      key_iv = r_iv;
      key_id = r_id;
    end
    for (int i = 0; i < CAPACITY; i++) begin
      le[i] = (CW'(i) < count) && (d_q[i] <= key);
    end
  end

  always_ff @(posedge clk) begin
    if (do_ins) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (!le[i]) begin
          if (i == 0 || le[(i == 0) ? 0 : i - 1]) begin
            d_q[i]  <= key;
            iv_q[i] <= key_iv;
            id_q[i] <= key_id;
          end else begin
            d_q[i]  <= d_q[(i == 0) ? 0 : i - 1];
            iv_q[i] <= iv_q[(i == 0) ? 0 : i - 1];
            id_q[i] <= id_q[(i == 0) ? 0 : i - 1];
          end
        end
      end
    end else if (cmd.do_pop) begin
      for (int i = 0; i < CAPACITY - 1; i++) begin
        d_q[i]  <= d_q[i + 1];
        iv_q[i] <= iv_q[i + 1];
        id_q[i] <= id_q[i + 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      min_delay <= MIN_DELAY_RST;
    end else begin
      if (cfg_wr_en) min_delay <= cfg_wr_data;
      if (do_ins) count <= count + CW'(1);
      else if (cmd.do_pop) count <= count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      r_action <= in_ch.action;
      r_id     <= in_ch.timer_id;
      r_dl     <= in_ch.deadline;
      r_iv     <= in_ch.repeat_interval;
      r_now    <= in_ch.now;
      ec       <= 1'b0;
      ov       <= 1'b0;
    end
    if (cmd.do_add) begin
      ov <= full;
      ec <= !full && (!nonempty || r_dl < d_q[0]);
    end
    if (cmd.do_pop) begin
      h_id <= id_q[0];
      h_iv <= iv_q[0];
    end
  end

  assign diff = (d_q[0] > r_now) ? d_q[0] - r_now : '0;
  assign ad   = (diff < {{(TM_W - IV_W){1'b0}}, min_delay}) ?
                {{(TM_W - IV_W){1'b0}}, min_delay} : diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (cmd.load_fire || cmd.load_stat) begin
      o_valid <= 1'b1;
    end else if (out_ch.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_fire) begin
      o_kind <= 1'b0;
      o_id   <= h_id;
      o_ec   <= 1'b0;
      o_ov   <= 1'b0;
      o_ne   <= 1'b0;
      o_nd   <= '0;
      o_ad   <= '0;
      o_last <= 1'b0;
    end else if (cmd.load_stat) begin
      o_kind <= 1'b1;
      o_id   <= '0;
      o_ec   <= ec;
      o_ov   <= ov;
      o_ne   <= nonempty;
      o_nd   <= nonempty ? d_q[0] : '0;
      o_ad   <= nonempty ? ad : '0;
      o_last <= 1'b1;
    end
  end

  assign stat.is_tick      = r_action;
  assign stat.expired      = nonempty && (d_q[0] < r_now);
  assign stat.reins_needed = h_iv != '0;
  assign stat.out_free     = !o_valid || out_ch.ready;

  assign in_ch.ready             = cmd.latch_in;

  assign out_ch.valid            = o_valid;
  assign out_ch.kind             = o_kind;
  assign out_ch.fired_id         = o_id;
  assign out_ch.head_changed     = o_ec;
  assign out_ch.overflow         = o_ov;
  assign out_ch.queue_nonempty   = o_ne;
  assign out_ch.next_deadline    = o_nd;
  assign out_ch.arm_delay        = o_ad;
  assign out_ch.last             = o_last;

  `OTQ_ASSERT(a_count_bound, count <= CW'(CAPACITY), "count above capacity")
  `OTQ_ASSERT(a_pop_count, cmd.do_pop |=> count == $past(count) - CW'(1), "pop miscount")
  `OTQ_ASSERT(a_sorted, count >= CW'(2) |-> d_q[0] <= d_q[1], "queue head out of order")
  `OTQ_ASSERT(a_no_lost_out, o_valid && !out_ch.ready |-> !(cmd.load_fire || cmd.load_stat), "output overwritten")
endmodule

>>> sv/ordered_timer_queue.sv
// sorted timer queue, one add or tick item at a time
// add: the item is latched, inserted in ST_ADD, then its status is loaded in ST_STAT
// tick: each expired head is popped and fired, and reinserted if it repeats, then the
// status is loaded; output stalls hold fire and status; the next item is taken in ST_IDLE
// reset: queue empty, min_arm_delay 100, output empty; no clearing pass
module ordered_timer_queue import otq_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_wr_en,
  input  logic [IV_W-1:0] cfg_wr_data,
  otq_in_if.sink          in_ch,
  otq_out_if.source       out_ch
);
  cmd_t  cmd;
  stat_t stat;

  otq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .stat     (stat),
    .cmd      (cmd)
  );

  otq_dp #(.CAPACITY(CAPACITY)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cmd         (cmd),
    .stat        (stat)
  );
endmodule
